FILE: hw/rtl/rmssd_pkg.sv
// Shared types and constants for the mirrored shadow span decoder.
`default_nettype none
package rmssd_pkg;

  localparam int XW = 19;

  localparam logic [7:0] RUN_MASK     = 8'd127;
  localparam logic [7:0] END_CODE     = 8'd0;
  localparam logic [7:0] NEWLINE_CODE = 8'd0;

  localparam logic OP_START = 1'b0;
  localparam logic OP_CODE  = 1'b1;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_CLIP_WIDTH  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CLIP_HEIGHT = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DIM_LEVEL   = 3'd4;

  localparam logic [14:0] CLIP_WIDTH_RST  = 15'd640;
  localparam logic [14:0] CLIP_HEIGHT_RST = 15'd480;

  typedef struct packed {
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic [14:0]        clip_width;
    logic [14:0]        clip_height;
    logic [7:0]         dim_level;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [7:0]         code_byte;
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic signed [15:0] frame_x_offset;
    logic signed [15:0] frame_y_offset;
    logic [14:0]        frame_width;
    logic [14:0]        frame_height;
    logic               clip_request;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] span_row;
    logic signed [15:0] span_start;
    logic [6:0]         span_length;
    logic [7:0]         palette_level;
    logic               sprite_done;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rmssd_cfg_regs.sv
// Configuration register file: clip rectangle and dimming level.
`default_nettype none
module rmssd_cfg_regs
  import rmssd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left   <= '0;
      cfg_r.clip_top    <= '0;
      cfg_r.clip_width  <= CLIP_WIDTH_RST;
      cfg_r.clip_height <= CLIP_HEIGHT_RST;
      cfg_r.dim_level   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LEFT:   cfg_r.clip_left   <= $signed(cfg_data);
        CFG_CLIP_TOP:    cfg_r.clip_top    <= $signed(cfg_data);
        CFG_CLIP_WIDTH:  cfg_r.clip_width  <= cfg_data[14:0];
        CFG_CLIP_HEIGHT: cfg_r.clip_height <= cfg_data[14:0];
        CFG_DIM_LEVEL:   cfg_r.dim_level   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rmssd_in_stage.sv
// Input register stage holding one accepted item.
`default_nettype none
module rmssd_in_stage
  import rmssd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  input  wire logic advance,
  output logic      item_valid,
  output in_item_t  item
);

  logic     valid_r;
  logic     valid_nxt;
  logic     take;
  in_item_t item_r;

  assign in_stall  = valid_r & ~advance;
  assign take      = in_valid & ~in_stall;
  assign valid_nxt = take | (valid_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

FILE: hw/rtl/rmssd_decode.sv
// Decoder state and single-pass decode of one item into at most one span or end marker.
`default_nettype none
module rmssd_decode
  import rmssd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_hit,
  output res_t      res
);

  logic signed [15:0] cur_col_r,   cur_col_nxt;
  logic signed [15:0] right_col_r, right_col_nxt;
  logic signed [15:0] cur_row_r,   cur_row_nxt;
  logic               clip_active_r, clip_active_nxt;

  logic signed [XW-1:0] ax, ay, fx, fy, fw, fh;
  logic signed [XW-1:0] cl, ct, cw, ch;
  logic signed [XW-1:0] left, left_end, top, col, row, rr, start;
  logic                 fits, keep;
  logic [7:0]           b, count;

  always_comb begin
    ax = XW'(item.anchor_x);
    ay = XW'(item.anchor_y);
    fx = XW'(item.frame_x_offset);
    fy = XW'(item.frame_y_offset);
    fw = $signed(XW'(item.frame_width));
    fh = $signed(XW'(item.frame_height));
    cl = XW'(cfg.clip_left);
    ct = XW'(cfg.clip_top);
    cw = $signed(XW'(cfg.clip_width));
    ch = $signed(XW'(cfg.clip_height));

    left     = ax - fx - fw + XW'(1);
    left_end = ax - fx + XW'(1);
    top      = ay + fy;
    fits     = (left >= cl) && (left_end <= cl + cw) &&
               (top >= ct) && (top + fh <= ct + ch);

    b     = item.code_byte;
    count = b & RUN_MASK;
    col   = XW'(cur_col_r);
    row   = XW'(cur_row_r);
    rr    = $signed(XW'(b));
    start = col - rr + XW'(1);
    keep  = ~clip_active_r ||
            ((row >= ct) && (row <= ct + ch - XW'(1)) &&
             (start >= cl) && (col <= cl + cw - XW'(1)));

    cur_col_nxt     = cur_col_r;
    right_col_nxt   = right_col_r;
    cur_row_nxt     = cur_row_r;
    clip_active_nxt = clip_active_r;
    res_hit         = 1'b0;
    res             = '0;

    if (item.op == OP_START) begin
      clip_active_nxt = item.clip_request & ~fits;
      right_col_nxt   = item.anchor_x - item.frame_x_offset;
      cur_col_nxt     = right_col_nxt;
      cur_row_nxt     = top[15:0];
    end else if (b[7]) begin
      if (count == END_CODE) begin
        res_hit         = 1'b1;
        res.sprite_done = 1'b1;
      end else begin
        cur_col_nxt = cur_col_r - $signed({8'd0, count});
      end
    end else if (b == NEWLINE_CODE) begin
      cur_col_nxt = right_col_r;
      cur_row_nxt = cur_row_r + 16'sd1;
    end else if (b != 8'd0) begin
      res_hit           = keep;
      res.span_row      = cur_row_r;
      res.span_start    = start[15:0];
      res.span_length   = b[6:0];
      res.palette_level = cfg.dim_level;
      cur_col_nxt       = cur_col_r - $signed({8'd0, b});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r     <= '0;
      right_col_r   <= '0;
      cur_row_r     <= '0;
      clip_active_r <= 1'b0;
    end else if (fire) begin
      cur_col_r     <= cur_col_nxt;
      right_col_r   <= right_col_nxt;
      cur_row_r     <= cur_row_nxt;
      clip_active_r <= clip_active_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rle_mirrored_shadow_span_decoder.sv
// Top level of the mirrored run-length shadow span decoder.
// Accepts one item per cycle and keeps that rate under any stall pattern
// that leaves the output free. An accepted item is held in the input
// register, is decoded in a single pass against the column, row and clip
// state, and any span or end marker is registered in the output register.
// Start items and skip, newline, zero-length or clipped runs give no
// result. The clip rectangle and dimming level are read live when each run
// is decoded.
`default_nettype none
module rle_mirrored_shadow_span_decoder
  import rmssd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [CFG_DW-1:0]  cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic [7:0]         in_code_byte,
  input  wire logic signed [15:0] in_anchor_x,
  input  wire logic signed [15:0] in_anchor_y,
  input  wire logic signed [15:0] in_frame_x_offset,
  input  wire logic signed [15:0] in_frame_y_offset,
  input  wire logic [14:0]        in_frame_width,
  input  wire logic [14:0]        in_frame_height,
  input  wire logic               in_clip_request,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_span_row,
  output logic signed [15:0]      out_span_start,
  output logic [6:0]              out_span_length,
  output logic [7:0]              out_palette_level,
  output logic                    out_sprite_done
);

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     fire;
  logic     res_hit;
  res_t     res;
  logic     out_valid_r;
  logic     out_valid_nxt;
  res_t     out_r;

  assign in_item.op             = in_op;
  assign in_item.code_byte      = in_code_byte;
  assign in_item.anchor_x       = in_anchor_x;
  assign in_item.anchor_y       = in_anchor_y;
  assign in_item.frame_x_offset = in_frame_x_offset;
  assign in_item.frame_y_offset = in_frame_y_offset;
  assign in_item.frame_width    = in_frame_width;
  assign in_item.frame_height   = in_frame_height;
  assign in_item.clip_request   = in_clip_request;

  rmssd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rmssd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  assign advance = ~out_valid_r | ~out_stall;
  assign fire    = item_valid & advance;

  rmssd_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item),
    .cfg     (cfg),
    .res_hit (res_hit),
    .res     (res)
  );

  assign out_valid_nxt = advance ? (fire & res_hit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_span_row      = out_r.span_row;
  assign out_span_start    = out_r.span_start;
  assign out_span_length   = out_r.span_length;
  assign out_palette_level = out_r.palette_level;
  assign out_sprite_done   = out_r.sprite_done;

  a_done_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sprite_done |-> out_span_length == 7'd0 && out_span_row == 16'sd0)
    else $error("end marker carries span data");

  a_span_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sprite_done |-> out_span_length != 7'd0)
    else $error("zero-length span delivered");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && out_valid && out_stall |=> item_valid && $stable(item))
    else $error("buffered item lost under output stall");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |-> !in_stall)
    else $error("input stalled with empty input register");

endmodule
`default_nettype wire

FILE: bench/rmssd_span_checker.sv
// Span checker: predicts decoder results from the watched channels and compares them.
module rmssd_span_checker
  import rmssd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [CFG_DW-1:0]  cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               in_op,
  input  wire logic [7:0]         in_code_byte,
  input  wire logic signed [15:0] in_anchor_x,
  input  wire logic signed [15:0] in_anchor_y,
  input  wire logic signed [15:0] in_frame_x_offset,
  input  wire logic signed [15:0] in_frame_y_offset,
  input  wire logic [14:0]        in_frame_width,
  input  wire logic [14:0]        in_frame_height,
  input  wire logic               in_clip_request,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [15:0] out_span_row,
  input  wire logic signed [15:0] out_span_start,
  input  wire logic [6:0]         out_span_length,
  input  wire logic [7:0]         out_palette_level,
  input  wire logic               out_sprite_done,
  output int                      mismatches,
  output int                      pending,
  output int                      spans_checked,
  output int                      ends_checked,
  output int                      items_taken
);

  int         clip_l;
  int         clip_t;
  int         clip_w;
  int         clip_h;
  logic [7:0] dim;
  int         col;
  int         right_edge;
  int         row;
  bit         clip_on;
  res_t       spans_due[$];
  res_t       oldest;
  in_item_t   taken;

  function automatic int wrap16(input int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  task automatic decode_item(input in_item_t it);
    int         left;
    int         top;
    int         width;
    int         start;
    int         r;
    bit         fits;
    bit         keep;
    logic [7:0] cnt;
    res_t       span;
    span = '0;
    if (it.op == OP_START) begin
      width = int'(it.frame_width);
      left = int'($signed(it.anchor_x)) - int'($signed(it.frame_x_offset)) - width + 1;
      top = int'($signed(it.anchor_y)) + int'($signed(it.frame_y_offset));
      fits = left >= clip_l && left + width <= clip_l + clip_w &&
             top >= clip_t && top + int'(it.frame_height) <= clip_t + clip_h;
      clip_on = it.clip_request && !fits;
      right_edge = wrap16(left + width - 1);
      col = right_edge;
      row = wrap16(top);
    end else if (it.code_byte[7]) begin
      cnt = it.code_byte & RUN_MASK;
      if (cnt == END_CODE) begin
        span.sprite_done = 1'b1;
        spans_due.push_back(span);
      end else begin
        col = wrap16(col - int'(cnt));
      end
    end else if (it.code_byte == NEWLINE_CODE) begin
      col = right_edge;
      row = wrap16(row + 1);
    end else if (it.code_byte != 8'd0) begin
      r = int'(it.code_byte);
      start = col - r + 1;
      keep = !clip_on ||
             (row >= clip_t && row <= clip_t + clip_h - 1 &&
              start >= clip_l && col <= clip_l + clip_w - 1);
      if (keep) begin
        span.span_row = row[15:0];
        span.span_start = start[15:0];
        span.span_length = it.code_byte[6:0];
        span.palette_level = dim;
        spans_due.push_back(span);
      end
      col = wrap16(col - r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clip_l = 0;
      clip_t = 0;
      clip_w = int'(CLIP_WIDTH_RST);
      clip_h = int'(CLIP_HEIGHT_RST);
      dim = '0;
      col = 0;
      right_edge = 0;
      row = 0;
      clip_on = 1'b0;
      spans_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (spans_due.size() == 0) begin
          $error("unexpected result: row %0d start %0d length %0d done %0b",
                 out_span_row, out_span_start, out_span_length, out_sprite_done);
          mismatches++;
        end else begin
          oldest = spans_due.pop_front();
          if (oldest.sprite_done) ends_checked++;
          else spans_checked++;
          if (out_span_row !== oldest.span_row) begin
            $error("span_row: expected %0d, got %0d", oldest.span_row, out_span_row);
            mismatches++;
          end
          if (out_span_start !== oldest.span_start) begin
            $error("span_start: expected %0d, got %0d", oldest.span_start, out_span_start);
            mismatches++;
          end
          if (out_span_length !== oldest.span_length) begin
            $error("span_length: expected %0d, got %0d", oldest.span_length,
                   out_span_length);
            mismatches++;
          end
          if (out_palette_level !== oldest.palette_level) begin
            $error("palette_level: expected %0d, got %0d", oldest.palette_level,
                   out_palette_level);
            mismatches++;
          end
          if (out_sprite_done !== oldest.sprite_done) begin
            $error("sprite_done: expected %0b, got %0b", oldest.sprite_done,
                   out_sprite_done);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLIP_LEFT:   clip_l = int'($signed(cfg_data));
          CFG_CLIP_TOP:    clip_t = int'($signed(cfg_data));
          CFG_CLIP_WIDTH:  clip_w = int'(cfg_data[14:0]);
          CFG_CLIP_HEIGHT: clip_h = int'(cfg_data[14:0]);
          CFG_DIM_LEVEL:   dim = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        taken.op = in_op;
        taken.code_byte = in_code_byte;
        taken.anchor_x = in_anchor_x;
        taken.anchor_y = in_anchor_y;
        taken.frame_x_offset = in_frame_x_offset;
        taken.frame_y_offset = in_frame_y_offset;
        taken.frame_width = in_frame_width;
        taken.frame_height = in_frame_height;
        taken.clip_request = in_clip_request;
        items_taken++;
        decode_item(taken);
      end
    end
    pending = spans_due.size();
  end

endmodule

FILE: bench/rle_mirrored_shadow_span_decoder_tb.sv
// Testbench top: clock, reset, register settings, sprite and noise stimulus, plus the verdict.
module rle_mirrored_shadow_span_decoder_tb;
  import rmssd_pkg::*;

  localparam logic [7:0] SKIP_FLAG = 8'h80;
  localparam logic [7:0] END_BYTE  = SKIP_FLAG | END_CODE;
  localparam int         ITEM_GOAL = 1550;
  localparam int         PHASES    = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_IW-1:0]  cfg_index = '0;
  logic [CFG_DW-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_op = 1'b0;
  logic [7:0]         in_code_byte = '0;
  logic signed [15:0] in_anchor_x = '0;
  logic signed [15:0] in_anchor_y = '0;
  logic signed [15:0] in_frame_x_offset = '0;
  logic signed [15:0] in_frame_y_offset = '0;
  logic [14:0]        in_frame_width = '0;
  logic [14:0]        in_frame_height = '0;
  logic               in_clip_request = 1'b0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [15:0] out_span_row;
  logic signed [15:0] out_span_start;
  logic [6:0]         out_span_length;
  logic [7:0]         out_palette_level;
  logic               out_sprite_done;

  int mismatches;
  int pending;
  int spans_checked;
  int ends_checked;
  int items_taken;
  int sent = 0;
  int settings_used = 1;
  bit quiet = 1'b0;
  int rect_l = 0;
  int rect_t = 0;
  int rect_w = 640;
  int rect_h = 480;

  rle_mirrored_shadow_span_decoder u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_code_byte(in_code_byte), .in_anchor_x(in_anchor_x), .in_anchor_y(in_anchor_y),
    .in_frame_x_offset(in_frame_x_offset), .in_frame_y_offset(in_frame_y_offset),
    .in_frame_width(in_frame_width), .in_frame_height(in_frame_height),
    .in_clip_request(in_clip_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_span_row(out_span_row), .out_span_start(out_span_start),
    .out_span_length(out_span_length), .out_palette_level(out_palette_level),
    .out_sprite_done(out_sprite_done)
  );

  rmssd_span_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_code_byte(in_code_byte), .in_anchor_x(in_anchor_x), .in_anchor_y(in_anchor_y),
    .in_frame_x_offset(in_frame_x_offset), .in_frame_y_offset(in_frame_y_offset),
    .in_frame_width(in_frame_width), .in_frame_height(in_frame_height),
    .in_clip_request(in_clip_request),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_span_row(out_span_row), .out_span_start(out_span_start),
    .out_span_length(out_span_length), .out_palette_level(out_palette_level),
    .out_sprite_done(out_sprite_done),
    .mismatches(mismatches), .pending(pending), .spans_checked(spans_checked),
    .ends_checked(ends_checked), .items_taken(items_taken)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("rle_mirrored_shadow_span_decoder regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 28);
  end

  function automatic in_item_t noise_item();
    logic [127:0] raw;
    in_item_t     it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t code_item(input logic [7:0] b);
    in_item_t it;
    it = noise_item();
    it.op = OP_CODE;
    it.code_byte = b;
    return it;
  endfunction

  function automatic in_item_t start_item(input int ax, input int ay, input int fx,
                                          input int fy, input int fw, input int fh,
                                          input bit req);
    in_item_t it;
    it = noise_item();
    it.op = OP_START;
    it.anchor_x = ax[15:0];
    it.anchor_y = ay[15:0];
    it.frame_x_offset = fx[15:0];
    it.frame_y_offset = fy[15:0];
    it.frame_width = fw[14:0];
    it.frame_height = fh[14:0];
    it.clip_request = req;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_code_byte <= it.code_byte;
    in_anchor_x <= it.anchor_x;
    in_anchor_y <= it.anchor_y;
    in_frame_x_offset <= it.frame_x_offset;
    in_frame_y_offset <= it.frame_y_offset;
    in_frame_width <= it.frame_width;
    in_frame_height <= it.frame_height;
    in_clip_request <= it.clip_request;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input int l, input int t, input int w, input int h,
                              input int d);
    put_reg(CFG_CLIP_LEFT, l[15:0]);
    put_reg(CFG_CLIP_TOP, t[15:0]);
    put_reg(CFG_CLIP_WIDTH, w[15:0]);
    put_reg(CFG_CLIP_HEIGHT, h[15:0]);
    put_reg(CFG_DIM_LEVEL, d[15:0]);
    cfg_we <= 1'b0;
    @(posedge clk);
    rect_l = l;
    rect_t = t;
    rect_w = w;
    rect_h = h;
    settings_used++;
  endtask

  function automatic logic [7:0] run_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 127));
    return 8'($urandom_range(1, 12));
  endfunction

  function automatic logic [7:0] skip_byte();
    if ($urandom_range(0, 9) == 0) return SKIP_FLAG | 8'($urandom_range(1, 127));
    return SKIP_FLAG | 8'($urandom_range(1, 20));
  endfunction

  task automatic draw_sprite();
    int fw;
    int fh;
    int left;
    int top_row;
    int fx;
    int fy;
    int roll;
    roll = $urandom_range(0, 19);
    fw = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(0, 32767) : $urandom_range(1, 60);
    fh = (roll == 2) ? $urandom_range(0, 32767) : $urandom_range(1, 8);
    left = rect_l - 30 + $urandom_range(0, 30 + ((rect_w > 200) ? 200 : rect_w));
    top_row = rect_t - 4 + $urandom_range(0, 8 + ((rect_h > 64) ? 64 : rect_h));
    fx = $urandom_range(0, 200) - 100;
    fy = $urandom_range(0, 200) - 100;
    if ($urandom_range(0, 9) == 0)
      send_item(start_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           1'($urandom_range(0, 1))));
    else
      send_item(start_item(left + fx + fw - 1, top_row - fy, fx, fy, fw, fh,
                           $urandom_range(0, 3) != 0));
    for (int y = 0; y < ((fh > 6) ? 6 : fh); y++) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) < 7) send_item(code_item(run_byte()));
        else send_item(code_item(skip_byte()));
      end
      send_item(code_item(NEWLINE_CODE));
    end
    if ($urandom_range(0, 19) != 0) send_item(code_item(END_BYTE));
  endtask

  task automatic make_noise();
    in_item_t it;
    repeat ($urandom_range(1, 5)) begin
      it = noise_item();
      if ($urandom_range(0, 1) == 1) it.code_byte = END_BYTE;
      send_item(it);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(code_item(8'd5));
    send_item(start_item(100, 10, 0, 0, 20, 5, 1'b1));
    send_item(code_item(8'h7f));
    send_item(code_item(SKIP_FLAG | 8'd1));
    send_item(code_item(8'hff));
    send_item(code_item(NEWLINE_CODE));
    send_item(code_item(8'd1));
    send_item(code_item(END_BYTE));
    send_item(code_item(8'd3));
    send_item(start_item(5, 20, 0, 0, 20, 3, 1'b1));
    send_item(code_item(8'd2));
    send_item(code_item(8'd16));
    send_item(code_item(NEWLINE_CODE));
    send_item(code_item(8'h7f));
    send_item(start_item(-32768, 32767, 32767, 32767, 32767, 32767, 1'b1));
    send_item(code_item(8'h7f));
    send_item(code_item(NEWLINE_CODE));
    send_item(code_item(END_BYTE));
    send_item(start_item(32767, -32768, -32768, -32768, 0, 0, 1'b0));
    send_item(code_item(8'd64));
    send_item(code_item(END_BYTE));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(-32768, -32768, 32767, 32767, 255);
        1: program_regs(32767, 32767, 0, 0, 0);
        2: program_regs(-32768, 32767, 0, 32767, $urandom_range(0, 255));
        default: program_regs($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                              $urandom_range(1, 300), $urandom_range(1, 40),
                              $urandom_range(0, 255));
      endcase
      quiet = (p == 3);
      while (sent < 25 + (p + 1) * (ITEM_GOAL / PHASES)) begin
        if ($urandom_range(0, 9) == 0) make_noise();
        else draw_sprite();
      end
      settle();
    end
    quiet = 1'b0;

    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("covered %0d items over %0d register settings: %0d spans and %0d ends checked",
             items_taken, settings_used, spans_checked, ends_checked);
    if (mismatches == 0 && pending == 0)
      $display("rle_mirrored_shadow_span_decoder regression: pass");
    else
      $display("rle_mirrored_shadow_span_decoder regression: fail");
    $finish;
  end

endmodule
